/* rtl/cnms_pkg.sv */
`default_nettype none
package cnms_pkg;

    // Default sizes
    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int CLASS_BITS_DEF = 8;

    // Threshold register, unsigned Q1.16
    localparam int                  THR_BITS  = 17;
    localparam logic [THR_BITS-1:0] THR_RESET = 17'd32768;

    // Configuration map: word index taken from paddr[2]
    localparam int   ADDR_BITS          = 3;
    localparam logic REG_IOU_THRESHOLD  = 1'b0;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [15:0] x_left;
        logic [15:0] y_top;
        logic [15:0] x_right;
        logic [15:0] y_bottom;
        logic [15:0] box_score;
        logic [7:0]  class_id;
        logic        last_box;
    } t_box_in;

    typedef struct packed {
        logic [15:0] out_x_left;
        logic [15:0] out_y_top;
        logic [15:0] out_x_right;
        logic [15:0] out_y_bottom;
        logic [15:0] out_score;
        logic [7:0]  out_class;
        logic        out_last;
        logic        out_overflow;
    } t_box_out;

    typedef struct packed {
        t_box_in box;
        logic    drop;
    } t_qword;

endpackage
`default_nettype wire

/* rtl/class_aware_nms.sv */
`default_nettype none
// Class-aware greedy non-maximum suppression.
// Input: one box per word on i_box, taken at a clock edge with start high and
// busy low. Boxes load at one per cycle through a four-word queue; busy rises
// only while that queue is full. The word with last_box closes the set.
// Once closed, the back end ranks the set by descending score (ties in arrival
// order), then walks the ranking: each kept box is read and checked against
// every later unsuppressed box, one of another class after its read, one of the
// same class through the overlap multiply chain; suppressed boxes are skipped
// unread, and a last step flushes the final result.
// Output: each kept box appears on o_result for one cycle with o_valid high,
// in rank order, the final one with out_last set; the receiver cannot stall.
// out_overflow reports boxes dropped beyond MAX_BOXES in that set.
// The user must write the threshold over the APB port at address 0 only while
// the block is idle; the block does not enforce this. Reset clears the queue,
// the set and the marks and loads the threshold 0.5.
module class_aware_nms #(
    parameter int MAX_BOXES  = cnms_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = cnms_pkg::COORD_BITS_DEF,
    parameter int CLASS_BITS = cnms_pkg::CLASS_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  cnms_pkg::t_box_in                 i_box,
    output logic                              o_valid,
    output cnms_pkg::t_box_out                o_result,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [cnms_pkg::ADDR_BITS-1:0]     paddr,
    input  wire [31:0]                        pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import cnms_pkg::*;

    logic [THR_BITS-1:0] r_thr;
    logic                f_push;
    t_qword              f_word;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    t_qword              q_word;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IOU_THRESHOLD) ? 32'(r_thr) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_IOU_THRESHOLD) begin
            r_thr <= pwdata[THR_BITS-1:0];
        end
    end

    cnms_front #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS),
        .CLASS_BITS (CLASS_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_box   (i_box),
        .o_push  (f_push),
        .o_word  (f_word),
        .i_full  (q_full)
    );

    cnms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_word  (f_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_word  (q_word)
    );

    cnms_back #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS),
        .CLASS_BITS (CLASS_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_thr     (r_thr),
        .i_q_valid (q_valid),
        .i_q_word  (q_word),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

/* rtl/cnms_front.sv */
`default_nettype none
module cnms_front #(
    parameter int MAX_BOXES  = cnms_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = cnms_pkg::COORD_BITS_DEF,
    parameter int CLASS_BITS = cnms_pkg::CLASS_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    output logic                o_busy,
    input  cnms_pkg::t_box_in   i_box,
    output logic                o_push,
    output cnms_pkg::t_qword    o_word,
    input  wire                 i_full
);
    import cnms_pkg::*;

    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam logic [15:0] CMASK  = 16'((32'd1 << COORD_BITS) - 1);
    localparam logic [7:0]  CLMASK = 8'((32'd1 << CLASS_BITS) - 1);

    logic             r_valid;
    t_qword           r_word;
    logic [CNT_W-1:0] r_cnt;
    logic             accept;
    logic             drop;
    t_box_in          m_box;

    // Stall input only when the staged word cannot move on
    assign o_busy = r_valid & i_full;
    assign accept = i_start & ~o_busy;
    assign o_push = r_valid & ~i_full;
    assign o_word = r_word;

    // Mask fields to the configured widths and flag boxes past capacity
    assign drop = (r_cnt == CNT_W'(MAX_BOXES));
    always_comb begin
        m_box          = i_box;
        m_box.x_left   = i_box.x_left & CMASK;
        m_box.y_top    = i_box.y_top & CMASK;
        m_box.x_right  = i_box.x_right & CMASK;
        m_box.y_bottom = i_box.y_bottom & CMASK;
        m_box.class_id = i_box.class_id & CLMASK;
    end

    // Track staging and the per-set count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
            if (accept) begin
                if (i_box.last_box) begin
                    r_cnt <= '0;
                end else if (!drop) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Hold the classified word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.box  <= m_box;
            r_word.drop <= drop;
        end
    end

endmodule
`default_nettype wire

/* rtl/cnms_queue.sv */
`default_nettype none
module cnms_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  cnms_pkg::t_qword  i_word,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_valid,
    output cnms_pkg::t_qword  o_word
);
    import cnms_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_qword        r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          push;
    logic          pop;

    assign o_full  = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rp];
    assign push    = i_push & ~o_full;
    assign pop     = i_pop & o_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule
`default_nettype wire

/* rtl/cnms_back.sv */
`default_nettype none
module cnms_back #(
    parameter int MAX_BOXES  = cnms_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = cnms_pkg::COORD_BITS_DEF,
    parameter int CLASS_BITS = cnms_pkg::CLASS_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire [cnms_pkg::THR_BITS-1:0]     i_thr,
    input  wire                              i_q_valid,
    input  cnms_pkg::t_qword                 i_q_word,
    output logic                             o_q_pop,
    output logic                             o_valid,
    output cnms_pkg::t_box_out               o_result
);
    import cnms_pkg::*;

    localparam int IW    = $clog2(MAX_BOXES);
    localparam int CNT_W = IW + 1;
    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int AW    = 2 * DW;
    localparam int IN_W  = 2 * CW;
    localparam int UW    = AW + 1;
    localparam int CMP_W = THR_BITS + UW - 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RK_I, S_RK_IW, S_RK_J, S_RK_JW, S_RK_WR,
        S_SP_I, S_SP_IW, S_SP_A, S_SP_J, S_SP_JW, S_SP_B,
        S_SP_C2, S_SP_C3, S_SP_C4
    } t_state;

    // Box stores and rank table
    logic [4*CW-1:0]       r_corner_mem [MAX_BOXES];
    logic [15:0]           r_score_mem  [MAX_BOXES];
    logic [CLASS_BITS-1:0] r_class_mem  [MAX_BOXES];
    logic [IW-1:0]         r_rank_mem   [MAX_BOXES];

    logic [4*CW-1:0]       r_rd_corner;
    logic [15:0]           r_rd_score;
    logic [CLASS_BITS-1:0] r_rd_class;
    logic [IW-1:0]         r_rd_rank;

    t_state                r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_n;
    logic [CNT_W-1:0]      r_i;
    logic [CNT_W-1:0]      r_j;
    logic [CNT_W-1:0]      r_rk;
    logic                  r_ovf;
    logic [15:0]           r_si;
    logic [MAX_BOXES-1:0]  r_supp;
    logic                  r_pv;
    t_box_out              r_pend;
    logic                  r_valid;
    t_box_out              r_result;

    logic [4*CW-1:0]       r_a_corner;
    logic [CLASS_BITS-1:0] r_a_class;
    logic signed [AW-1:0]  r_area_a;
    logic signed [AW-1:0]  r_area_b;
    logic [IN_W-1:0]       r_inter;
    logic signed [UW-1:0]  r_uni;
    logic [CMP_W-1:0]      r_prod;
    logic                  r_zero;

    logic                  load_we;
    logic [IW-1:0]         box_addr;
    logic [IW-1:0]         rank_addr;
    logic                  rank_we;
    logic [IN_W-1:0]       inter_c;
    logic                  hit;

    function automatic logic [CW-1:0] fld(input logic [4*CW-1:0] c, input int k);
        fld = c[k*CW +: CW];
    endfunction

    function automatic logic signed [AW-1:0] area_of(input logic [4*CW-1:0] c);
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        dx = $signed({1'b0, fld(c, 2)}) - $signed({1'b0, fld(c, 0)});
        dy = $signed({1'b0, fld(c, 3)}) - $signed({1'b0, fld(c, 1)});
        area_of = dx * dy;
    endfunction

    function automatic logic [CW-1:0] span(input logic [CW-1:0] lo_a,
                                           input logic [CW-1:0] lo_b,
                                           input logic [CW-1:0] hi_a,
                                           input logic [CW-1:0] hi_b);
        logic [CW-1:0]        lo;
        logic [CW-1:0]        hi;
        logic signed [DW-1:0] d;
        lo = (lo_a > lo_b) ? lo_a : lo_b;
        hi = (hi_a < hi_b) ? hi_a : hi_b;
        d  = $signed({1'b0, hi}) - $signed({1'b0, lo});
        span = d[DW-1] ? '0 : d[CW-1:0];
    endfunction

    assign o_q_pop  = (r_state == S_IDLE) & i_q_valid;
    assign load_we  = o_q_pop & ~i_q_word.drop;
    assign rank_we  = (r_state == S_RK_WR);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Intersection of box A with the box just read
    assign inter_c = span(fld(r_a_corner, 0), fld(r_rd_corner, 0),
                          fld(r_a_corner, 2), fld(r_rd_corner, 2))
                   * span(fld(r_a_corner, 1), fld(r_rd_corner, 1),
                          fld(r_a_corner, 3), fld(r_rd_corner, 3));

    // Final overlap decision
    assign hit = r_zero ? (i_thr == '0)
                        : (CMP_W'({r_inter, 16'b0}) >= r_prod);

    // Select read addresses by phase
    always_comb begin
        case (r_state)
            S_RK_I:            box_addr = r_i[IW-1:0];
            S_RK_J:            box_addr = r_j[IW-1:0];
            S_SP_IW, S_SP_JW:  box_addr = r_rd_rank;
            default:           box_addr = r_cnt[IW-1:0];
        endcase
        case (r_state)
            S_SP_J:   rank_addr = r_j[IW-1:0];
            default:  rank_addr = r_i[IW-1:0];
        endcase
    end

    // Box stores: write on load, registered read
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_corner_mem[r_cnt[IW-1:0]] <= {i_q_word.box.y_bottom[CW-1:0],
                                            i_q_word.box.x_right[CW-1:0],
                                            i_q_word.box.y_top[CW-1:0],
                                            i_q_word.box.x_left[CW-1:0]};
            r_score_mem[r_cnt[IW-1:0]]  <= i_q_word.box.box_score;
            r_class_mem[r_cnt[IW-1:0]]  <= i_q_word.box.class_id[CLASS_BITS-1:0];
        end
        r_rd_corner <= r_corner_mem[box_addr];
        r_rd_score  <= r_score_mem[box_addr];
        r_rd_class  <= r_class_mem[box_addr];
    end

    // Rank table
    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            r_rank_mem[r_rk[IW-1:0]] <= r_i[IW-1:0];
        end
        r_rd_rank <= r_rank_mem[rank_addr];
    end

    // Sequencer: load, rank, suppress, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_rk    <= '0;
            r_ovf   <= 1'b0;
            r_supp  <= '0;
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_word.drop) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (i_q_word.box.last_box) begin
                            r_n     <= i_q_word.drop ? r_cnt : r_cnt + 1'b1;
                            r_i     <= '0;
                            r_state <= S_RK_I;
                        end
                    end
                end
                S_RK_I: begin
                    r_state <= S_RK_IW;
                end
                S_RK_IW: begin
                    r_si    <= r_rd_score;
                    r_j     <= '0;
                    r_rk    <= '0;
                    r_state <= S_RK_J;
                end
                S_RK_J: begin
                    r_state <= S_RK_JW;
                end
                S_RK_JW: begin
                    // count boxes ranked ahead: higher score, or equal and earlier
                    if (r_rd_score > r_si || (r_rd_score == r_si && r_j < r_i)) begin
                        r_rk <= r_rk + 1'b1;
                    end
                    if (r_j == r_n - 1'b1) begin
                        r_state <= S_RK_WR;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RK_J;
                    end
                end
                S_RK_WR: begin
                    if (r_i == r_n - 1'b1) begin
                        r_i     <= '0;
                        r_state <= S_SP_I;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RK_I;
                    end
                end
                S_SP_I: begin
                    if (r_i == r_n) begin
                        // flush the last kept box and empty the set
                        r_valid  <= 1'b1;
                        r_result <= {r_pend[$bits(t_box_out)-1:2], 1'b1,
                                     r_pend.out_overflow};
                        r_cnt    <= '0;
                        r_ovf    <= 1'b0;
                        r_supp   <= '0;
                        r_pv     <= 1'b0;
                        r_state  <= S_IDLE;
                    end else if (r_supp[r_i[IW-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_state <= S_SP_IW;
                    end
                end
                S_SP_IW: begin
                    r_state <= S_SP_A;
                end
                S_SP_A: begin
                    // emit the previous kept box, hold this one
                    if (r_pv) begin
                        r_valid  <= 1'b1;
                        r_result <= r_pend;
                    end
                    r_pv       <= 1'b1;
                    r_pend     <= {16'(fld(r_rd_corner, 0)),
                                   16'(fld(r_rd_corner, 1)),
                                   16'(fld(r_rd_corner, 2)),
                                   16'(fld(r_rd_corner, 3)),
                                   r_rd_score,
                                   8'(r_rd_class),
                                   1'b0,
                                   r_ovf};
                    r_a_corner <= r_rd_corner;
                    r_a_class  <= r_rd_class;
                    r_area_a   <= area_of(r_rd_corner);
                    r_j        <= r_i + 1'b1;
                    r_state    <= S_SP_J;
                end
                S_SP_J: begin
                    if (r_j == r_n) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SP_I;
                    end else if (r_supp[r_j[IW-1:0]]) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_state <= S_SP_JW;
                    end
                end
                S_SP_JW: begin
                    r_state <= S_SP_B;
                end
                S_SP_B: begin
                    if (r_rd_class != r_a_class) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_SP_J;
                    end else begin
                        r_inter  <= inter_c;
                        r_area_b <= area_of(r_rd_corner);
                        r_state  <= S_SP_C2;
                    end
                end
                S_SP_C2: begin
                    r_uni   <= UW'(r_area_a) + UW'(r_area_b)
                             - $signed({{(UW-IN_W){1'b0}}, r_inter});
                    r_state <= S_SP_C3;
                end
                S_SP_C3: begin
                    r_zero  <= (r_inter == '0) || (r_uni <= 0);
                    r_prod  <= {{(UW-1){1'b0}}, i_thr}
                             * {{THR_BITS{1'b0}}, r_uni[UW-2:0]};
                    r_state <= S_SP_C4;
                end
                S_SP_C4: begin
                    if (hit) begin
                        r_supp[r_j[IW-1:0]] <= 1'b1;
                    end
                    r_j     <= r_j + 1'b1;
                    r_state <= S_SP_J;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
